// ===== hw/rtl/bitplane_framebuffer_writer_macros.svh =====
// Assertion macros shared by the bitplane framebuffer writer checkers.
// No dependencies; included by the checker module.
`ifndef BITPLANE_FRAMEBUFFER_WRITER_MACROS_SVH
`define BITPLANE_FRAMEBUFFER_WRITER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define BFW_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BFW_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bfw_pkg.sv =====
// Shared types and constants for the bitplane framebuffer writer.
// No dependencies; imported by every module of the block.
package bfw_pkg;

    // Request opcodes carried on s_tuser
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INVERT = 2'd1,
        OP_PIXEL  = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    // Configuration register indexes
    localparam logic [2:0] CFG_DISPLAY_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_DISPLAY_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_LINE_STEP      = 3'd2;
    localparam logic [2:0] CFG_PLANE_BYTES    = 3'd3;
    localparam logic [2:0] CFG_IMAGE_WIDTH    = 3'd4;
    localparam logic [2:0] CFG_IMAGE_HEIGHT   = 3'd5;
    localparam logic [2:0] CFG_RED_THRESHOLD  = 3'd6;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Register reset values
    localparam logic [10:0] RST_DISPLAY_WIDTH  = 11'd1024;
    localparam logic [10:0] RST_DISPLAY_HEIGHT = 11'd1024;
    localparam logic [7:0]  RST_LINE_STEP      = 8'd128;
    localparam logic [14:0] RST_PLANE_BYTES    = 15'd16384;
    localparam logic [10:0] RST_IMAGE_WIDTH    = 11'd1024;
    localparam logic [10:0] RST_IMAGE_HEIGHT   = 11'd1024;
    localparam logic [15:0] RST_RED_THRESHOLD  = 16'd0;

    // Stream payload layout
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 1;

    localparam int PLANE_LSB = 0;
    localparam int POS_X_LSB = 1;
    localparam int POS_Y_LSB = 11;
    localparam int RED_LSB   = 21;
    localparam int BIDX_LSB  = 37;

    localparam logic [7:0] BYTE_ALL_ONES = 8'hff;
    localparam logic [7:0] BIT_MSB_MASK  = 8'h80;

    // Controller to datapath commands
    typedef struct packed {
        logic latch;        // capture accepted request
        logic pix_a;        // centre pixel, range checks
        logic pix_b;        // row times line step plus column byte
        logic pix_c;        // plane bound check, read byte
        logic pix_wr;       // write back modified byte
        logic rd_issue;     // read-byte lookup
        logic walk_step;    // one clear/invert walk position
        logic walk_wr;      // invert write back
        logic load_result;  // move result into output register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic walk_done;
        logic walk_rmw;
        logic out_free;
    } status_t;

endpackage

// ===== hw/rtl/bfw_ctrl.sv =====
// Sequencer for the bitplane framebuffer writer.
// Depends on bfw_pkg for the command and status structs.
module bfw_ctrl
    import bfw_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // op[1:0]
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  status_t              status,
    output cmd_t                 cmd
);

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_PIX_A   = 9'b000000010,
        ST_PIX_B   = 9'b000000100,
        ST_PIX_C   = 9'b000001000,
        ST_PIX_D   = 9'b000010000,
        ST_RD      = 9'b000100000,
        ST_WALK    = 9'b001000000,
        ST_WALK_WR = 9'b010000000,
        ST_FIN     = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // Next state and command decode
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch = 1'b1;
                    // first working state follows the opcode of the live request
                    unique case (op_t'(s_tuser)) inside
                        OP_CLEAR, OP_INVERT: state_next = ST_WALK;
                        OP_PIXEL:            state_next = ST_PIX_A;
                        OP_READ:             state_next = ST_RD;
                    endcase
                end
            end
            ST_PIX_A: begin
                cmd.pix_a  = 1'b1;
                state_next = ST_PIX_B;
            end
            ST_PIX_B: begin
                cmd.pix_b  = 1'b1;
                state_next = ST_PIX_C;
            end
            ST_PIX_C: begin
                cmd.pix_c  = 1'b1;
                state_next = ST_PIX_D;
            end
            ST_PIX_D: begin
                cmd.pix_wr = 1'b1;
                state_next = ST_FIN;
            end
            ST_RD: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_FIN;
            end
            ST_WALK: begin
                cmd.walk_step = 1'b1;
                if (status.walk_done) begin
                    state_next = ST_FIN;
                end else if (status.walk_rmw) begin
                    state_next = ST_WALK_WR;
                end
            end
            ST_WALK_WR: begin
                cmd.walk_wr = 1'b1;
                state_next  = ST_WALK;
            end
            ST_FIN: begin
                if (status.out_free) begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/bfw_datapath.sv =====
// Datapath of the bitplane framebuffer writer: registers, address math,
// byte store and result register. Depends on bfw_pkg.
module bfw_datapath
    import bfw_pkg::*;
#(
    parameter int PLANE_COUNT = 2,
    parameter int PLANE_DEPTH = 16384
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic [S_TUSER_W-1:0]   s_tuser,
    input  cmd_t                   cmd,
    output status_t                status,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,
    output logic [M_TUSER_W-1:0]   m_tuser
);

    localparam int unsigned STORE_SIZE = PLANE_COUNT * PLANE_DEPTH;
    localparam int MEM_AW    = $clog2(STORE_SIZE);
    localparam int CALC_W    = (MEM_AW > 16) ? MEM_AW : 16;
    localparam logic PLANE1_OK = (PLANE_COUNT > 1);

    // Configuration registers
    logic [10:0] disp_w_reg, disp_h_reg, img_w_reg, img_h_reg;
    logic [7:0]  line_step_reg;
    logic [14:0] plane_bytes_reg;
    logic [15:0] red_thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disp_w_reg      <= RST_DISPLAY_WIDTH;
            disp_h_reg      <= RST_DISPLAY_HEIGHT;
            line_step_reg   <= RST_LINE_STEP;
            plane_bytes_reg <= RST_PLANE_BYTES;
            img_w_reg       <= RST_IMAGE_WIDTH;
            img_h_reg       <= RST_IMAGE_HEIGHT;
            red_thr_reg     <= RST_RED_THRESHOLD;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_DISPLAY_WIDTH:  disp_w_reg      <= cfg_wr_data[10:0];
                CFG_DISPLAY_HEIGHT: disp_h_reg      <= cfg_wr_data[10:0];
                CFG_LINE_STEP:      line_step_reg   <= cfg_wr_data[7:0];
                CFG_PLANE_BYTES:    plane_bytes_reg <= cfg_wr_data[14:0];
                CFG_IMAGE_WIDTH:    img_w_reg       <= cfg_wr_data[10:0];
                CFG_IMAGE_HEIGHT:   img_h_reg       <= cfg_wr_data[10:0];
                CFG_RED_THRESHOLD:  red_thr_reg     <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Request registers
    op_t         op_reg;
    logic        plane_reg;
    logic [9:0]  pos_x_reg, pos_y_reg;
    logic [15:0] red_reg;
    logic [13:0] bidx_reg;

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_reg    <= op_t'(s_tuser);
            plane_reg <= s_tdata[PLANE_LSB];
            pos_x_reg <= s_tdata[POS_X_LSB +: 10];
            pos_y_reg <= s_tdata[POS_Y_LSB +: 10];
            red_reg   <= s_tdata[RED_LSB +: 16];
            bidx_reg  <= s_tdata[BIDX_LSB +: 14];
        end
    end

    // Centring: (display - image) / 2, truncated toward zero, plus position
    logic [11:0] diff_x, diff_y, adj_x, adj_y;
    logic [12:0] dx_full, dy_full;
    logic        pix_range_drop;

    always_comb begin
        diff_x  = {1'b0, disp_w_reg} - {1'b0, img_w_reg};
        diff_y  = {1'b0, disp_h_reg} - {1'b0, img_h_reg};
        adj_x   = diff_x + {11'd0, diff_x[11]};
        adj_y   = diff_y + {11'd0, diff_y[11]};
        dx_full = {adj_x[11], adj_x[11], adj_x[11:1]} + {3'd0, pos_x_reg};
        dy_full = {adj_y[11], adj_y[11], adj_y[11:1]} + {3'd0, pos_y_reg};
        pix_range_drop = ({1'b0, pos_x_reg} >= img_w_reg) ||
                         ({1'b0, pos_y_reg} >= img_h_reg) ||
                         dx_full[12] || dy_full[12] ||
                         (dx_full[11:0] >= {1'b0, disp_w_reg}) ||
                         (dy_full[11:0] >= {1'b0, disp_h_reg});
    end

    // Shared absolute address adder and store bound check
    logic [14:0]       walk_reg;
    logic [19:0]       off_reg;
    logic [14:0]       off_sel;
    logic [CALC_W-1:0] base, addr_sum;
    logic              plane_ok, in_store, off_in, rd_ok, walk_done;

    always_comb begin
        if (cmd.pix_c) begin
            off_sel = off_reg[14:0];
        end else if (cmd.rd_issue) begin
            off_sel = {1'b0, bidx_reg};
        end else begin
            off_sel = walk_reg;
        end
        base     = {{(CALC_W-15){1'b0}}, plane_bytes_reg} & {CALC_W{plane_reg}};
        addr_sum = base + {{(CALC_W-15){1'b0}}, off_sel};
        plane_ok = !plane_reg || PLANE1_OK;
        in_store = plane_ok && (32'(addr_sum) < STORE_SIZE);
        off_in   = off_reg < {5'd0, plane_bytes_reg};
        rd_ok    = ({1'b0, bidx_reg} < plane_bytes_reg) && in_store;
        walk_done = walk_reg >= plane_bytes_reg;
    end

    // Pixel and walk working registers
    logic [10:0]       dx_reg, dy_reg;
    logic              drop_reg;
    logic [MEM_AW-1:0] addr_reg;
    logic              pix_ok;

    assign pix_ok = !drop_reg && off_in && in_store;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_reg <= '0;
            drop_reg <= 1'b0;
        end else begin
            if (cmd.latch || cmd.load_result) begin
                walk_reg <= '0;
            end else if ((cmd.walk_step && !walk_done && !status.walk_rmw) ||
                         cmd.walk_wr) begin
                walk_reg <= walk_reg + 15'd1;
            end
            if (cmd.latch) begin
                drop_reg <= 1'b0;
            end else if (cmd.pix_a) begin
                drop_reg <= pix_range_drop;
            end else if (cmd.pix_c) begin
                drop_reg <= !pix_ok;
            end else if (cmd.rd_issue) begin
                drop_reg <= !rd_ok;
            end else if (cmd.walk_step && !walk_done && !in_store) begin
                drop_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pix_a) begin
            dx_reg <= dx_full[10:0];
            dy_reg <= dy_full[10:0];
        end
        if (cmd.pix_b) begin
            off_reg <= ({12'd0, line_step_reg} * {9'd0, dy_reg}) + {12'd0, dx_reg[10:3]};
        end
        if (cmd.pix_c || cmd.walk_step) begin
            addr_reg <= addr_sum[MEM_AW-1:0];
        end
    end

    // Byte store: one port, registered read
    logic [7:0]        mem [STORE_SIZE];
    logic [7:0]        rdata_reg;
    logic [7:0]        wdata, pix_mask;
    logic              mem_we, mem_re;
    logic [MEM_AW-1:0] mem_addr;

    always_comb begin
        pix_mask = BIT_MSB_MASK >> dx_reg[2:0];
        mem_addr = (cmd.pix_wr || cmd.walk_wr) ? addr_reg : addr_sum[MEM_AW-1:0];
        mem_re   = (cmd.pix_c && pix_ok) || (cmd.rd_issue && rd_ok) ||
                   (cmd.walk_step && status.walk_rmw);
        mem_we   = (cmd.pix_wr && !drop_reg) || cmd.walk_wr ||
                   (cmd.walk_step && !walk_done && in_store && op_reg == OP_CLEAR);
        if (cmd.pix_wr) begin
            wdata = (red_reg > red_thr_reg) ? (rdata_reg | pix_mask)
                                            : (rdata_reg & ~pix_mask);
        end else if (cmd.walk_wr) begin
            wdata = ~rdata_reg;
        end else begin
            wdata = BYTE_ALL_ONES;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_addr];
        end
    end

    // Output register
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_drop_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_result) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            out_byte_reg <= (op_reg == OP_READ && !drop_reg) ? rdata_reg : 8'd0;
            out_drop_reg <= drop_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_drop_reg;

    // Status back to the sequencer
    assign status.walk_done = walk_done;
    assign status.walk_rmw  = !walk_done && in_store && op_reg == OP_INVERT;
    assign status.out_free  = !out_valid_reg || m_tready;

endmodule

// ===== hw/rtl/bitplane_framebuffer_writer.sv =====
// Top level of the bitplane framebuffer writer.
// Depends on bfw_pkg, bfw_ctrl and bfw_datapath.
//
// Usage: requests enter on the s_ stream (op on s_tuser), one result per
// request leaves on the m_ stream (stored byte on m_tdata, drop flag on
// m_tuser). Registers must be written on the cfg_wr_* port while idle;
// the block itself does not enforce this. It works on one request at a
// time, and s_tready returns in the same cycle that the result appears.
// Steps from acceptance to the result:
//   read byte   lookup, result load
//   write pixel centring, multiply, bound check and byte read, write back,
//               result load
//   clear       one store write per cycle, then result load
//   invert      read then write per byte, then result load
// The single-port byte store makes invert read and write each byte in turn.
// s_tready is high whenever no request is in progress, even while a
// finished result still sits in the output register. If the receiver
// stalls, the next request runs and then holds until the register frees.
// Reset clears the sequencer and the output valid flag and restores register
// defaults; the store contents are not cleared.
module bitplane_framebuffer_writer
    import bfw_pkg::*;
#(
    parameter int PLANE_COUNT = 2,
    parameter int PLANE_DEPTH = 16384
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // plane[0], pos_x[10:1], pos_y[20:11], red[36:21], byte_index[50:37], zero pad
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // op[1:0]
    input  logic [S_TUSER_W-1:0]   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // read_byte[7:0]
    output logic [M_TDATA_W-1:0]   m_tdata,
    // dropped[0]
    output logic [M_TUSER_W-1:0]   m_tuser
);

    cmd_t    cmd;
    status_t status;

    bfw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    bfw_datapath #(
        .PLANE_COUNT (PLANE_COUNT),
        .PLANE_DEPTH (PLANE_DEPTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .cmd          (cmd),
        .status       (status),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

endmodule

// ===== hw/rtl/bfw_checker.sv =====
// Port-level assertions for the bitplane framebuffer writer, bound to the
// top level. Depends on bfw_pkg and bitplane_framebuffer_writer_macros.svh.
`include "bitplane_framebuffer_writer_macros.svh"

module bfw_checker
    import bfw_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    // A stalled result holds its payload
    `BFW_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // A dropped request never returns a byte
    `BFW_ASSERT_IMP(a_drop_zero, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == '0, "dropped result carries a byte")

    // One request at a time: after acceptance the input side closes
    `BFW_ASSERT_NXT(a_one_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready, "request accepted while busy")

    // A new result is posted only as the block goes idle
    `BFW_ASSERT_IMP(a_post_idle, aclk, aresetn, $rose(m_tvalid), s_tready, "result posted while busy")

endmodule

bind bitplane_framebuffer_writer bfw_checker u_bfw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
